// File: rtl/dabti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dabti_pkg
// Shared constants, types and the branch delay map of the DAB time
// de-interleaver.
// ----------------------------------------------------------------------------
package dabti_pkg;

  localparam int MaxCus     = 1024;
  localparam int CuValues   = 64;
  localparam int Branches   = 16;

  localparam int DataW      = 16;
  localparam int CuW        = 11;
  localparam int CusM1W     = $clog2(MaxCus);
  localparam int CuValW     = $clog2(CuValues);
  localparam int PosW       = CusM1W + CuValW;
  localparam int BranchW    = $clog2(Branches);
  localparam int AddrW      = BranchW + PosW;
  localparam int FillW      = BranchW + 1;

  localparam logic [FillW-1:0] FillFull = FillW'(Branches);
  localparam logic [CuW-1:0]   CuReset  = CuW'(1);

  typedef logic [DataW-1:0] soft_t;
  typedef logic [AddrW-1:0] addr_t;

  typedef struct packed {
    addr_t rd_addr;
    addr_t wr_addr;
    logic  emit;
    logic  last;
  } ctrl_t;

  function automatic logic [BranchW-1:0] branch_map(input logic [BranchW-1:0] idx);
    logic [BranchW-1:0] rev;
    for (int b = 0; b < BranchW; b++) begin
      rev[b] = idx[BranchW-1-b];
    end
    return rev;
  endfunction

endpackage
`default_nettype wire

// File: rtl/dab_time_deinterleaver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dab_time_deinterleaver
// 16-branch DAB time de-interleaver built around one branch store RAM.
//
//   channel  signals                                   direction
//   cfg      cfg_valid_i cfg_ready_o cfg_cu_count_i    in
//   in       in_valid_i in_ready_o soft_in_i           in
//   out      out_valid_o out_ready_i soft_out_o
//            fragment_end_o                            out
//
// One value per cycle while the output is not stalled; each transfer does one
// RAM read and one RAM write. A result passes through the RAM read register,
// then the output register. Results of the first 16 fragments are dropped.
// Reset clears position, branch and fill count; the RAM is not cleared.
// A stalled output holds the RAM read register and the output register.
// ----------------------------------------------------------------------------
module dab_time_deinterleaver import dabti_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CuW-1:0]   cfg_cu_count_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic signed [DataW-1:0] soft_in_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic signed [DataW-1:0] soft_out_o,
  output logic                  fragment_end_o
);

  logic [CuW-1:0] cu_count_q;
  ctrl_t          ctrl;
  logic           in_accept;
  soft_t          rd_data;

  logic           s1_valid_q, s1_valid_d;
  logic           s1_last_q;
  logic           s1_adv;

  logic           out_valid_q, out_valid_d;
  soft_t          soft_out_q;
  logic           frag_end_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cu_count_q <= CuReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cu_count_q <= cfg_cu_count_i;
    end
  end

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  dabti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .cu_count_i (cu_count_q),
    .ctrl_o     (ctrl)
  );

  dabti_ram #(
    .AddrW (AddrW),
    .DataW (DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (ctrl.wr_addr),
    .wdata_i (soft_in_i),
    .re_i    (in_accept),
    .raddr_i (ctrl.rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = ctrl.emit;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_last_q <= ctrl.last;
    end
    if (s1_adv && s1_valid_q) begin
      soft_out_q <= rd_data;
      frag_end_q <= s1_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign soft_out_o     = soft_out_q;
  assign fragment_end_o = frag_end_q;

  a_fill_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !ctrl.emit |=> !s1_valid_q)
    else $error("result produced during fill phase");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_last_q) && $stable(rd_data))
    else $error("read stage lost while output stalled");

  a_no_accept_on_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while both stages are full");

endmodule
`default_nettype wire

// File: rtl/dabti_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dabti_ram
// Simple dual-port RAM, one write and one registered read per cycle,
// read-first on address collision.
// ----------------------------------------------------------------------------
module dabti_ram #(
  parameter int AddrW = 20,
  parameter int DataW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [2**AddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/dabti_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dabti_ctrl
// Position, current branch and fill tracking; forms the read and write
// addresses of the branch store for the next transfer.
// ----------------------------------------------------------------------------
module dabti_ctrl import dabti_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [CuW-1:0] cu_count_i,
  output ctrl_t               ctrl_o
);

  logic [PosW-1:0]    pos_q, pos_d;
  logic [BranchW-1:0] branch_q, branch_d;
  logic [FillW-1:0]   fill_q, fill_d;

  logic [CusM1W-1:0]  cus_m1;
  logic [PosW-1:0]    last_pos;
  logic [PosW-1:0]    pos_eff;
  logic [BranchW-1:0] src_branch;
  logic               last;
  logic               emit;

  // clamp the register to 1..MaxCus
  always_comb begin
    if (cu_count_i == '0) begin
      cus_m1 = '0;
    end else if (cu_count_i > CuW'(MaxCus)) begin
      cus_m1 = '1;
    end else begin
      cus_m1 = CusM1W'(cu_count_i - CuW'(1));
    end
  end

  assign last_pos   = {cus_m1, {CuValW{1'b1}}};
  assign last       = (pos_q >= last_pos);
  assign pos_eff    = last ? last_pos : pos_q;
  assign src_branch = branch_q + branch_map(pos_eff[BranchW-1:0]);
  assign emit       = (fill_q == FillFull);

  always_comb begin
    pos_d    = pos_q;
    branch_d = branch_q;
    fill_d   = fill_q;
    if (accept_i) begin
      if (last) begin
        pos_d    = '0;
        branch_d = branch_q + BranchW'(1);
        if (!emit) begin
          fill_d = fill_q + FillW'(1);
        end
      end else begin
        pos_d = pos_eff + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      branch_q <= '0;
      fill_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      branch_q <= branch_d;
      fill_q   <= fill_d;
    end
  end

  assign ctrl_o.rd_addr = {src_branch, pos_eff};
  assign ctrl_o.wr_addr = {branch_q, pos_eff};
  assign ctrl_o.emit    = emit;
  assign ctrl_o.last    = last;

endmodule
`default_nettype wire
